// ===== rtl/newton_square_root_top_assert.svh =====
// ---------------------------------------------------------------------------
// newton_square_root_top assertion macros
// property shorthands with the block clock and reset built in
// ---------------------------------------------------------------------------
`ifndef NEWTON_SQUARE_ROOT_TOP_ASSERT_SVH
`define NEWTON_SQUARE_ROOT_TOP_ASSERT_SVH

// same-cycle implication
`define NSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nsr_pkg.sv =====
// ---------------------------------------------------------------------------
// nsr_pkg
// widths, register codes and shared types of the newton square root block
// ---------------------------------------------------------------------------
package nsr_pkg;

  localparam int DATA_WIDTH     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int ROOT_WIDTH     = 24;
  localparam int LIMIT_WIDTH    = 8;
  localparam int TOL_WIDTH      = 16;
  localparam int CFG_IDX_WIDTH  = 8;
  localparam int CFG_DATA_WIDTH = 16;

  localparam int DIV_STEPS = DATA_WIDTH + FRAC_BITS;
  localparam int CNT_WIDTH = $clog2(DIV_STEPS + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ITER_LIMIT = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TOLERANCE  = CFG_IDX_WIDTH'(1);

  localparam logic [LIMIT_WIDTH-1:0] ITER_LIMIT_RST = LIMIT_WIDTH'(50);
  localparam logic [TOL_WIDTH-1:0]   TOLERANCE_RST  = TOL_WIDTH'(2);

  localparam logic [DATA_WIDTH-1:0] FIX_ONE  = DATA_WIDTH'(1) << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] ROOT_MAX = DATA_WIDTH'((64'd1 << ROOT_WIDTH) - 64'd1);

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // clamp a guess to the root field
  function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [DATA_WIDTH-1:0] val);
    logic [ROOT_WIDTH-1:0] res;
    if (val > ROOT_MAX) begin
      res = {ROOT_WIDTH{1'b1}};
    end else begin
      res = val[ROOT_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/nsr_if.sv =====
// ---------------------------------------------------------------------------
// nsr interfaces
// valid/ready channels for radicand, result and register writes
// ---------------------------------------------------------------------------
interface nsr_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [nsr_pkg::DATA_WIDTH-1:0]     radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface nsr_out_if;
  logic                              valid;
  logic                              ready;
  logic [nsr_pkg::ROOT_WIDTH-1:0]    root;
  logic                              converged;

  modport source (output valid, output root, output converged, input ready);
  modport sink   (input valid, input root, input converged, output ready);
endinterface

interface nsr_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [nsr_pkg::CFG_IDX_WIDTH-1:0]     index;
  logic [nsr_pkg::CFG_DATA_WIDTH-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/nsr_div.sv =====
// ---------------------------------------------------------------------------
// nsr_div
// restoring fixed-point divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module nsr_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [nsr_pkg::DATA_WIDTH-1:0]    num_i,
  input  logic [nsr_pkg::DATA_WIDTH-1:0]    den_i,
  output logic [nsr_pkg::DATA_WIDTH-1:0]    quo_o,
  output nsr_pkg::div_status_t              status_o
);

  localparam int DW = nsr_pkg::DATA_WIDTH;
  localparam int SW = nsr_pkg::DIV_STEPS;

  logic [SW-1:0]                   sh_q, sh_d;
  logic [DW-1:0]                   den_q, den_d;
  logic [DW-1:0]                   rem_q, rem_d;
  logic [DW-1:0]                   quo_q, quo_d;
  logic [nsr_pkg::CNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic                            done_q, done_d;
  logic [DW:0]                     rem_s;
  logic [DW:0]                     rem_sub;
  logic                            ge;

  // shift in the next dividend bit and try the subtract
  assign rem_s   = {rem_q, sh_q[SW-1]};
  assign rem_sub = rem_s - {1'b0, den_q};
  assign ge      = (rem_s >= {1'b0, den_q});

  always_comb begin
    sh_d   = sh_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d  = {num_i, {nsr_pkg::FRAC_BITS{1'b0}}};
      den_d = den_i;
      rem_d = '0;
      quo_d = '0;
      cnt_d = nsr_pkg::CNT_WIDTH'(SW);
    end else if (cnt_q != '0) begin
      sh_d  = {sh_q[SW-2:0], 1'b0};
      rem_d = ge ? rem_sub[DW-1:0] : rem_s[DW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - nsr_pkg::CNT_WIDTH'(1);
      if (cnt_q == nsr_pkg::CNT_WIDTH'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_o         = quo_q;
  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;

endmodule

// ===== rtl/newton_square_root_top.sv =====
// ---------------------------------------------------------------------------
// newton_square_root_top
// Newton-Raphson square root of a signed Q.16 radicand
//
// in_i carries one radicand per transaction; out_o returns root and the
// converged flag, one transaction per radicand, in order. cfg_i writes
// iteration_limit (index 0) and tolerance_lsb (index 1); other indexes are
// dropped. cfg_i is always ready; the user is to write it only while the
// block is idle, which the block itself does not enforce. Each Newton
// step runs the shared 48-step restoring divider, one quotient bit per
// cycle; an item runs n steps before its result is valid, n being 1 up to
// iteration_limit; a radicand that is zero or negative, or a zero limit,
// skips the divider. in_i is ready only while no item is in work. The
// result sits in an output register: a new radicand is taken while it
// waits, and a finished item holds in the sequencer until that register
// frees up. Reset empties the output, idles the sequencer and loads
// iteration_limit = 50 and tolerance_lsb = 2.
// ---------------------------------------------------------------------------
`include "newton_square_root_top_assert.svh"

module newton_square_root_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  nsr_in_if.sink       in_i,
  nsr_out_if.source    out_o,
  nsr_cfg_if.sink      cfg_i
);

  localparam int DW = nsr_pkg::DATA_WIDTH;
  localparam int LW = nsr_pkg::LIMIT_WIDTH;
  localparam int TW = nsr_pkg::TOL_WIDTH;
  localparam int RW = nsr_pkg::ROOT_WIDTH;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [LW-1:0]  limit_q, limit_d;
  logic [TW-1:0]  tol_q, tol_d;
  logic [LW-1:0]  iter_q, iter_d;
  logic [DW-1:0]  x_q, x_d;
  logic [DW-1:0]  guess_q, guess_d;
  logic [RW-1:0]  res_root_q, res_root_d;
  logic           res_conv_q, res_conv_d;
  logic           out_valid_q, out_valid_d;
  logic [RW-1:0]  out_root_q, out_root_d;
  logic           out_conv_q, out_conv_d;

  logic                  in_take;
  logic                  out_load;
  logic                  div_start;
  logic [DW-1:0]         quo;
  nsr_pkg::div_status_t  div_stat;
  logic [DW:0]           sum;
  logic [DW-1:0]         newton_est;
  logic [DW-1:0]         diff;
  logic [DW-1:0]         x_in;
  logic [DW-1:0]         half_x;
  logic [LW-1:0]         iter_inc;

  // shared divider: floor(x * 2^16 / guess)
  nsr_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (x_q),
    .den_i    (guess_q),
    .quo_o    (quo),
    .status_o (div_stat)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_take     = in_i.valid && in_i.ready;
  assign div_start   = (state_q == ST_START);
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign x_in       = DW'(unsigned'(in_i.radicand));
  assign half_x     = x_in >> 1;
  assign sum        = {1'b0, guess_q} + {1'b0, quo};
  assign newton_est = sum[DW:1];
  assign diff       = (newton_est >= guess_q) ? (newton_est - guess_q)
                                              : (guess_q - newton_est);
  assign iter_inc   = iter_q + LW'(1);

  // register writes
  always_comb begin
    limit_d = limit_q;
    tol_d   = tol_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        nsr_pkg::REG_ITER_LIMIT: limit_d = cfg_i.data[LW-1:0];
        nsr_pkg::REG_TOLERANCE:  tol_d   = cfg_i.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    x_d        = x_q;
    guess_d    = guess_q;
    res_root_d = res_root_q;
    res_conv_d = res_conv_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          x_d    = x_in;
          iter_d = '0;
          if (x_in == '0 || x_in[DW-1]) begin
            res_root_d = '0;
            res_conv_d = 1'b1;
            state_d    = ST_DONE;
          end else begin
            guess_d = (half_x < nsr_pkg::FIX_ONE) ? nsr_pkg::FIX_ONE : half_x;
            if (limit_q == '0) begin
              res_root_d = nsr_pkg::sat_root(guess_d);
              res_conv_d = 1'b0;
              state_d    = ST_DONE;
            end else begin
              state_d = ST_START;
            end
          end
        end
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          guess_d = newton_est;
          iter_d  = iter_inc;
          if (diff < DW'(tol_q)) begin
            res_root_d = nsr_pkg::sat_root(newton_est);
            res_conv_d = 1'b1;
            state_d    = ST_DONE;
          end else if (iter_inc == limit_q) begin
            res_root_d = nsr_pkg::sat_root(newton_est);
            res_conv_d = 1'b0;
            state_d    = ST_DONE;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_root_d  = out_root_q;
    out_conv_d  = out_conv_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_root_d  = res_root_q;
      out_conv_d  = res_conv_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= nsr_pkg::ITER_LIMIT_RST;
      tol_q       <= nsr_pkg::TOLERANCE_RST;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      tol_q       <= tol_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    guess_q    <= guess_d;
    res_root_q <= res_root_d;
    res_conv_q <= res_conv_d;
    out_root_q <= out_root_d;
    out_conv_q <= out_conv_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.root      = out_root_q;
  assign out_o.converged = out_conv_q;

  `NSR_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == ST_DIV,
                  "divider finished outside of a newton step")
  `NSR_ASSERT_IMP(a_iter_below_limit, state_q == ST_DIV, iter_q < limit_q,
                  "newton step count reached the limit while still running")
  `NSR_ASSERT_IMP(a_guess_nonzero, state_q == ST_DIV, guess_q != '0,
                  "divisor guess reached zero")
  `NSR_ASSERT_NXT(a_take_leaves_idle, in_take, state_q != ST_IDLE,
                  "accepted radicand did not start work")
  `NSR_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q == ST_DONE),
                  "result appeared without a finished item")

endmodule

// ===== tb/nsr_root_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// nsr_root_checker
// watches the radicand, result and register channels of the square root
// block, predicts root and converged flag for every radicand taken, and
// compares each returned result against the oldest prediction
// ---------------------------------------------------------------------------
module nsr_root_checker (
  input  logic clk_i,
  input  logic rst_ni,
  nsr_in_if    in_mon,
  nsr_out_if   out_mon,
  nsr_cfg_if   cfg_mon,
  output int   pending_count,
  output int   mismatch_count
);

  typedef struct packed {
    logic [nsr_pkg::ROOT_WIDTH-1:0] root;
    logic                           converged;
  } root_result_t;

  root_result_t                    expected_roots[$];
  logic [nsr_pkg::LIMIT_WIDTH-1:0] iter_limit;
  logic [nsr_pkg::TOL_WIDTH-1:0]   tolerance;
  int                              errors = 0;
  int                              results_seen = 0;

  // newton iteration on the scaled integer, quotient floored at each step
  function automatic root_result_t predict_root(
      input logic [nsr_pkg::DATA_WIDTH-1:0]  rad,
      input logic [nsr_pkg::LIMIT_WIDTH-1:0] limit,
      input logic [nsr_pkg::TOL_WIDTH-1:0]   tol);
    root_result_t res;
    logic [63:0]  estimate;
    logic [63:0]  quotient;
    logic [63:0]  refined;
    logic [63:0]  delta;
    int           step;
    res.root      = '0;
    res.converged = 1'b1;
    if (rad == '0 || rad[nsr_pkg::DATA_WIDTH-1]) begin
      return res;
    end
    res.converged = 1'b0;
    estimate = 64'(rad >> 1);
    if (estimate < nsr_pkg::FIX_ONE) begin
      estimate = 64'(nsr_pkg::FIX_ONE);
    end
    step = 0;
    while (step < int'(limit) && !res.converged) begin
      quotient = ({32'd0, rad} << nsr_pkg::FRAC_BITS) / estimate;
      refined  = (estimate + quotient) >> 1;
      delta    = (refined >= estimate) ? refined - estimate : estimate - refined;
      estimate = refined;
      if (delta < 64'(tol)) begin
        res.converged = 1'b1;
      end
      step++;
    end
    if (estimate > 64'(nsr_pkg::ROOT_MAX)) begin
      res.root = '1;
    end else begin
      res.root = estimate[nsr_pkg::ROOT_WIDTH-1:0];
    end
    return res;
  endfunction

  task automatic flag_error(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    errors++;
    if (errors <= 10) begin
      $display("%0t ns: result %0d %s: expected %0h got %0h",
               $time, results_seen, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    root_result_t want;
    if (!rst_ni) begin
      iter_limit = nsr_pkg::ITER_LIMIT_RST;
      tolerance  = nsr_pkg::TOLERANCE_RST;
      expected_roots.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          nsr_pkg::REG_ITER_LIMIT: iter_limit = cfg_mon.data[nsr_pkg::LIMIT_WIDTH-1:0];
          nsr_pkg::REG_TOLERANCE:  tolerance  = cfg_mon.data[nsr_pkg::TOL_WIDTH-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (expected_roots.size() == 0) begin
          flag_error("arrived with nothing expected, root", '0, 32'(out_mon.root));
        end else begin
          want = expected_roots.pop_front();
          if (out_mon.root !== want.root) begin
            flag_error("root", 32'(want.root), 32'(out_mon.root));
          end
          if (out_mon.converged !== want.converged) begin
            flag_error("converged", 32'(want.converged), 32'(out_mon.converged));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_roots.insert(expected_roots.size(),
                              predict_root(in_mon.radicand, iter_limit, tolerance));
      end
    end
    pending_count  <= expected_roots.size();
    mismatch_count <= errors;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// square root block driven with corner radicands and register settings,
// then random radicands over several limit and tolerance settings, with
// random idle bursts on both channels; results checked by nsr_root_checker
// ---------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 30_000_000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 215;
  localparam int TAIL_CYCLES = 120;

  localparam int DW  = nsr_pkg::DATA_WIDTH;
  localparam int LW  = nsr_pkg::LIMIT_WIDTH;
  localparam int TW  = nsr_pkg::TOL_WIDTH;
  localparam int IW  = nsr_pkg::CFG_IDX_WIDTH;
  localparam int CDW = nsr_pkg::CFG_DATA_WIDTH;

  // index outside the register map, writes to it are dropped
  localparam logic [IW-1:0] REG_UNMAPPED = IW'(7);

  logic clk_i;
  logic rst_ni;
  bit   idle_on = 1'b1;
  int   cycle_count = 0;
  int   pending_count;
  int   mismatch_count;

  logic [DW-1:0] corner_radicands [12] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h0000_0001, 32'h0000_FFFF, 32'h0001_0000, 32'h0002_0000,
    32'h0004_0000, 32'h5555_5555, 32'h2AAA_AAAA, 32'hFFFF_0000
  };

  nsr_in_if  in_bus ();
  nsr_out_if out_bus ();
  nsr_cfg_if cfg_bus ();

  newton_square_root_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  nsr_root_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .cfg_mon        (cfg_bus),
    .pending_count  (pending_count),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_radicand(input logic [DW-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.radicand <= value;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [IW-1:0] index,
                                input logic [CDW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
  endtask

  function automatic logic [DW-1:0] random_radicand();
    logic [DW-1:0] value;
    int unsigned   k;
    k = $urandom_range(1, 181);
    case ($urandom_range(0, 5))
      0: value = $urandom;
      1: value = $urandom_range(1, 32'h0003_FFFF);
      2: value = {1'b1, 31'($urandom)};
      3: value = (k * k) << nsr_pkg::FRAC_BITS;
      4: value = $urandom_range(0, 32'h0002_0000);
      default: value = {1'b0, 31'($urandom)};
    endcase
    return value;
  endfunction

  initial begin
    logic [LW-1:0] limit;
    logic [TW-1:0] tol;
    rst_ni          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.radicand = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = '0;
    cfg_bus.data    = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings on the corner values
    foreach (corner_radicands[i]) begin
      send_radicand(corner_radicands[i]);
    end

    // single step with no tolerance, big radicands saturate the root
    wait_drained();
    write_register(nsr_pkg::REG_ITER_LIMIT, 16'h3C01);
    write_register(nsr_pkg::REG_TOLERANCE, 16'h0000);
    send_radicand(32'h7FFF_FFFF);
    send_radicand(32'h0100_0000);
    send_radicand(32'hFFFF_FFFF);

    // zero limit returns the first guess
    wait_drained();
    write_register(REG_UNMAPPED, 16'hFFFF);
    write_register(nsr_pkg::REG_ITER_LIMIT, 16'hA500);
    send_radicand(32'h7FFF_FFFF);
    send_radicand(32'h0000_0001);
    send_radicand(32'h0003_0000);

    // longest run: full limit, tolerance never met
    wait_drained();
    write_register(nsr_pkg::REG_ITER_LIMIT, 16'h00FF);
    send_radicand(32'h0002_0000);
    send_radicand(32'h7FFF_FFFF);

    wait_drained();
    write_register(nsr_pkg::REG_TOLERANCE, 16'hFFFF);
    send_radicand(32'h4000_0000);
    send_radicand(32'h0000_0100);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin
          limit = LW'($urandom_range(1, 12));
          tol   = TW'($urandom_range(0, 8));
        end
        1: begin
          limit = LW'($urandom_range(1, 40));
          tol   = TW'($urandom_range(2, 300));
        end
        2: begin
          limit = 8'hFF;
          tol   = TW'($urandom_range(2, 65535));
        end
        default: begin
          limit = LW'($urandom_range(0, 6));
          tol   = TW'($urandom);
        end
      endcase
      if (phase == NUM_PHASES - 1) begin
        idle_on = 1'b0;
      end
      write_register(nsr_pkg::REG_ITER_LIMIT, {8'($urandom), limit});
      write_register(nsr_pkg::REG_TOLERANCE, tol);
      repeat (PHASE_ITEMS) send_radicand(random_radicand());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== newton_square_root_top.f =====
+incdir+rtl
rtl/nsr_pkg.sv
rtl/nsr_if.sv
rtl/nsr_div.sv
rtl/newton_square_root_top.sv
tb/nsr_root_checker.sv
tb/testbench.sv
